FILE: sv/utf8_stream_validator_core_defines.svh
// ----------------------------------------------------------------------------
// utf8_stream_validator_core_defines
// Assertion macros shared by the validator RTL. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clk edge outside reset.
`define UTF8SV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define UTF8SV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UTF8SV_ASSERT_IMPL(lbl, ante, cons, msg)
`define UTF8SV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/utf8sv_pkg.sv
// ----------------------------------------------------------------------------
// utf8sv_pkg
// Widths, constants and types shared by the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8sv_pkg;

    localparam int BYTE_W              = 8;
    localparam int COUNT_W             = 21;
    localparam int LENGTH_BITS_DEFAULT = 20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 21'h1F_FFFF;

    // lead-byte classification
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] CODE_LEAD2 = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] CODE_LEAD3 = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] CODE_LEAD4 = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] CODE_CONT  = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;

    localparam logic [2:0] LEAD4_MAX_BITS = 3'h4;
    localparam logic [4:0] LEAD2_MIN_BITS = 5'h02;

    // code point limits
    localparam logic [COUNT_W-1:0] CP_MIN_3BYTE = 21'h00_0800;
    localparam logic [COUNT_W-1:0] CP_MIN_4BYTE = 21'h01_0000;
    localparam logic [COUNT_W-1:0] CP_SURR_LO   = 21'h00_D800;
    localparam logic [COUNT_W-1:0] CP_SURR_HI   = 21'h00_DFFF;
    localparam logic [COUNT_W-1:0] CP_MAX       = 21'h10_FFFF;

    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    typedef struct packed {
        logic [1:0]         pending;
        logic [1:0]         seq_len;
        logic [COUNT_W-1:0] code_point;
        logic [COUNT_W-1:0] seen_bytes;
        logic               error_seen;
    } state_t;

    typedef struct packed {
        logic               is_valid;
        logic [COUNT_W-1:0] byte_count;
    } result_t;

endpackage

FILE: sv/utf8sv_step.sv
// ----------------------------------------------------------------------------
// utf8sv_step
// One-byte decode step: next string state and the verdict for an end marker.
// ----------------------------------------------------------------------------
module utf8sv_step
    import utf8sv_pkg::*;
(
    input  state_t              state,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                has_byte,
    input  logic                end_of_string,
    input  logic [COUNT_W-1:0]  max_length,
    output state_t              state_next,
    output result_t             result
);

    always_comb
    begin
        state_t s;
        logic [COUNT_W-1:0] cp_acc;
        logic [1:0]         pend_dec;

        s        = state;
        cp_acc   = '0;
        pend_dec = '0;

        if (has_byte)
        begin
            if (s.seen_bytes >= max_length)
            begin
                s.error_seen = 1'b1;
            end
            if ((s.seen_bytes <= max_length) && (s.seen_bytes != COUNT_MAX))
            begin
                s.seen_bytes = s.seen_bytes + COUNT_W'(1);
            end

            if (!s.error_seen)
            begin
                if (s.pending == 2'd0)
                begin
                    if (data_byte == '0)
                    begin
                        s.error_seen = 1'b1;
                    end
                    else if (data_byte <= ASCII_MAX)
                    begin
                        // plain ASCII, nothing to track
                    end
                    else if ((data_byte & MASK_LEAD2) == CODE_LEAD2)
                    begin
                        s.code_point = {16'd0, data_byte[4:0]};
                        if (data_byte[4:0] < LEAD2_MIN_BITS)
                        begin
                            s.error_seen = 1'b1;   // C0/C1 overlong lead
                        end
                        else
                        begin
                            s.seq_len = SEQ_TWO;
                            s.pending = 2'd1;
                        end
                    end
                    else if ((data_byte & MASK_LEAD3) == CODE_LEAD3)
                    begin
                        s.code_point = {17'd0, data_byte[3:0]};
                        s.seq_len    = SEQ_THREE;
                        s.pending    = 2'd2;
                    end
                    else if ((data_byte & MASK_LEAD4) == CODE_LEAD4)
                    begin
                        s.code_point = {18'd0, data_byte[2:0]};
                        if (data_byte[2:0] > LEAD4_MAX_BITS)
                        begin
                            s.error_seen = 1'b1;   // F5..F7
                        end
                        else
                        begin
                            s.seq_len = SEQ_FOUR;
                            s.pending = 2'd3;
                        end
                    end
                    else
                    begin
                        s.error_seen = 1'b1;
                    end
                end
                else if ((data_byte & MASK_CONT) != CODE_CONT)
                begin
                    s.error_seen = 1'b1;
                end
                else
                begin
                    cp_acc   = {s.code_point[14:0], data_byte[5:0]};
                    pend_dec = s.pending - 2'd1;
                    s.code_point = cp_acc;
                    s.pending    = pend_dec;
                    if (pend_dec == 2'd0)
                    begin
                        if ((s.seq_len == SEQ_THREE) && (cp_acc < CP_MIN_3BYTE))
                        begin
                            s.error_seen = 1'b1;
                        end
                        if ((s.seq_len == SEQ_FOUR) && (cp_acc < CP_MIN_4BYTE))
                        begin
                            s.error_seen = 1'b1;
                        end
                        if ((cp_acc >= CP_SURR_LO) && (cp_acc <= CP_SURR_HI))
                        begin
                            s.error_seen = 1'b1;
                        end
                        if (cp_acc > CP_MAX)
                        begin
                            s.error_seen = 1'b1;
                        end
                        s.seq_len    = SEQ_NONE;
                        s.code_point = '0;
                    end
                end
            end
        end

        if (end_of_string && (s.pending != 2'd0))
        begin
            s.error_seen = 1'b1;            // truncated sequence
        end

        result.is_valid   = ~s.error_seen;
        result.byte_count = s.seen_bytes;

        if (end_of_string)
        begin
            state_next = '0;
        end
        else
        begin
            state_next = s;
        end
    end

endmodule

FILE: sv/utf8_stream_validator_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// Strict UTF-8 checker for a byte stream with a programmable length limit.
//
// One byte is taken per clock while in_stall is low: the decode of a byte
// is a single step from the string state registers, so a byte follows the
// previous one in the next cycle. An item with end_of_string set loads the
// result register with the verdict and the byte count, saturated at
// max_length + 1, and the string state clears for the next string. in_stall
// rises only while a result waits in the result register and out_stall holds
// it. A bare end marker (has_byte low) closes a string without a byte; an
// item with both flags low does nothing. max_length is written through
// cfg_write_en / cfg_write_data and resets to 2^LENGTH_BITS, capped at
// 1FFFFF.
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_core_defines.svh"

module utf8_stream_validator_core
    import utf8sv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write_en,
    input  logic [COUNT_W-1:0] cfg_write_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               has_byte,
    input  logic               end_of_string,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_valid,
    output logic [COUNT_W-1:0] byte_count
);

    localparam longint unsigned LenPow = 64'd1 << LENGTH_BITS;
    localparam logic [COUNT_W-1:0] MaxLenReset =
        (LenPow > 64'(COUNT_MAX)) ? COUNT_MAX : LenPow[COUNT_W-1:0];

    logic [COUNT_W-1:0] max_length_reg;
    state_t             state_reg;
    state_t             state_next;
    result_t            step_result;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            result_reg;

    logic               in_accept;
    logic               out_accept;

    assign in_stall   = out_valid_reg & out_stall;
    assign in_accept  = in_valid & ~in_stall;
    assign out_accept = out_valid_reg & ~out_stall;

    utf8sv_step u_step (
        .state         (state_reg),
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .max_length    (max_length_reg),
        .state_next    (state_next),
        .result        (step_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
        if (in_accept && end_of_string)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MaxLenReset;
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_length_reg <= cfg_write_data;
            end
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a transaction closes a string
    always_ff @(posedge clk)
    begin
        if (in_accept && end_of_string)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_valid   = result_reg.is_valid;
    assign byte_count = result_reg.byte_count;

    `UTF8SV_ASSERT_NEXT(a_clear_after_end, in_accept && end_of_string,
        (state_reg.seen_bytes == '0) && (state_reg.pending == 2'd0) && !state_reg.error_seen,
        "string state not cleared after end marker")
    `UTF8SV_ASSERT_IMPL(a_pending_within_seq, state_reg.pending != 2'd0,
        (state_reg.seq_len != SEQ_NONE) && (state_reg.pending <= state_reg.seq_len),
        "pending continuations exceed sequence length")
    `UTF8SV_ASSERT_IMPL(a_result_source, $rose(out_valid_reg),
        $past(in_accept && end_of_string),
        "result appeared without an end marker")
    `UTF8SV_ASSERT_NEXT(a_result_held, out_valid_reg && out_stall,
        out_valid_reg && $stable(result_reg),
        "stalled result was lost or changed")

endmodule

FILE: dv/utf8_stream_validator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_checker
// Watches the byte and verdict channels of the validator, keeps its own
// model of the string decode, and compares every verdict transaction
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module utf8_stream_validator_checker
    import utf8sv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [COUNT_W-1:0] cfg_write_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               has_byte,
    input  logic               end_of_string,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               is_valid,
    input  logic [COUNT_W-1:0] byte_count,
    output int                 mismatches,
    output int                 pending_results,
    output int                 strings_seen,
    output int                 strings_valid
);

    localparam longint unsigned RESET_SPAN = 64'd1 << LENGTH_BITS;
    localparam logic [COUNT_W-1:0] LIMIT_AT_RESET =
        (RESET_SPAN > 64'(COUNT_MAX)) ? COUNT_MAX : RESET_SPAN[COUNT_W-1:0];

    logic [COUNT_W-1:0] limit_q;
    state_t             str_st;
    result_t            verdict_q[$];
    result_t            want;

    // one byte of decode, only called while the string is still clean
    function automatic void decode_utf8_byte(input logic [BYTE_W-1:0] b);
        if (str_st.pending == 2'd0)
        begin
            if (b == '0)
                str_st.error_seen = 1'b1;
            else if (b <= ASCII_MAX)
                str_st.error_seen = str_st.error_seen;
            else if ((b & MASK_LEAD2) == CODE_LEAD2)
            begin
                str_st.code_point = {16'd0, b[4:0]};
                if (b[4:0] < LEAD2_MIN_BITS)
                    str_st.error_seen = 1'b1;
                else
                begin
                    str_st.seq_len = SEQ_TWO;
                    str_st.pending = 2'd1;
                end
            end
            else if ((b & MASK_LEAD3) == CODE_LEAD3)
            begin
                str_st.code_point = {17'd0, b[3:0]};
                str_st.seq_len    = SEQ_THREE;
                str_st.pending    = 2'd2;
            end
            else if ((b & MASK_LEAD4) == CODE_LEAD4)
            begin
                str_st.code_point = {18'd0, b[2:0]};
                if (b[2:0] > LEAD4_MAX_BITS)
                    str_st.error_seen = 1'b1;
                else
                begin
                    str_st.seq_len = SEQ_FOUR;
                    str_st.pending = 2'd3;
                end
            end
            else
                str_st.error_seen = 1'b1;
        end
        else if ((b & MASK_CONT) != CODE_CONT)
            str_st.error_seen = 1'b1;
        else
        begin
            str_st.code_point = {str_st.code_point[14:0], b[5:0]};
            str_st.pending    = str_st.pending - 2'd1;
            if (str_st.pending == 2'd0)
            begin
                if (str_st.seq_len == SEQ_THREE && str_st.code_point < CP_MIN_3BYTE)
                    str_st.error_seen = 1'b1;
                if (str_st.seq_len == SEQ_FOUR && str_st.code_point < CP_MIN_4BYTE)
                    str_st.error_seen = 1'b1;
                if (str_st.code_point >= CP_SURR_LO && str_st.code_point <= CP_SURR_HI)
                    str_st.error_seen = 1'b1;
                if (str_st.code_point > CP_MAX)
                    str_st.error_seen = 1'b1;
                str_st.seq_len    = SEQ_NONE;
                str_st.code_point = '0;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_q = LIMIT_AT_RESET;
            str_st  = '0;
            verdict_q.delete();
            mismatches      = 0;
            strings_seen    = 0;
            strings_valid   = 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: verdict with nothing expected: is_valid=%0d count=%0d",
                             $time, is_valid, byte_count);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (is_valid !== want.is_valid)
                    begin
                        mismatches++;
                        $display("%0t: is_valid expected %0d, got %0d",
                                 $time, want.is_valid, is_valid);
                    end
                    if (byte_count !== want.byte_count)
                    begin
                        mismatches++;
                        $display("%0t: byte_count expected %0d, got %0d",
                                 $time, want.byte_count, byte_count);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (has_byte)
                begin
                    if (str_st.seen_bytes >= limit_q)
                        str_st.error_seen = 1'b1;
                    if (str_st.seen_bytes <= limit_q && str_st.seen_bytes != COUNT_MAX)
                        str_st.seen_bytes = str_st.seen_bytes + COUNT_W'(1);
                    if (!str_st.error_seen)
                        decode_utf8_byte(data_byte);
                end
                if (end_of_string)
                begin
                    // string cut off inside a sequence
                    if (str_st.pending != 2'd0)
                        str_st.error_seen = 1'b1;
                    want.is_valid   = !str_st.error_seen;
                    want.byte_count = str_st.seen_bytes;
                    verdict_q.insert(verdict_q.size(), want);
                    strings_seen++;
                    if (want.is_valid)
                        strings_valid++;
                    str_st = '0;
                end
            end

            if (cfg_write_en)
                limit_q = cfg_write_data;

            pending_results <= verdict_q.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the UTF-8 stream validator: directed strings for
// each class of encoding error, then random strings, mostly well formed,
// under a range of length limits with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import utf8sv_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int LONG_HOLD    = 300;
    localparam logic [COUNT_W-1:0] LIMIT_TOP = 21'd1048576;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_write_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_write_data = '0;
    logic               in_valid       = 1'b0;
    logic [BYTE_W-1:0]  data_byte      = '0;
    logic               has_byte       = 1'b0;
    logic               end_of_string  = 1'b0;
    logic               out_stall      = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               is_valid;
    logic [COUNT_W-1:0] byte_count;

    int mismatches;
    int pending_results;
    int strings_seen;
    int strings_valid;

    logic [BYTE_W-1:0] str_q[$];
    int  items_sent  = 0;
    int  strings_gen = 0;
    int  limits_used = 0;
    int  tx_max      = 15;
    int  rx_max      = 15;
    bit  hold_req    = 1'b0;

    utf8_stream_validator_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_string  (end_of_string),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_valid       (is_valid),
        .byte_count     (byte_count)
    );

    utf8_stream_validator_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .end_of_string   (end_of_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .is_valid        (is_valid),
        .byte_count      (byte_count),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .strings_seen    (strings_seen),
        .strings_valid   (strings_valid)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // verdict side: random stall before each transaction, one long hold on request
    initial
    begin
        int stall_n;
        int rx_done;
        rx_done = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_n  = LONG_HOLD;
            end
            else
                stall_n = $urandom_range(0, rx_max);
            if (stall_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            rx_done++;
            if (rx_done % 25 == 0)
                rx_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
        end
    end

    task automatic send_item(input logic [BYTE_W-1:0] b, input logic hb, input logic eos);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        has_byte      <= hb;
        end_of_string <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (hb || eos)
            items_sent++;
    endtask

    // append one byte to the string under construction
    task automatic put_byte(input logic [BYTE_W-1:0] b);
        str_q.insert(str_q.size(), b);
    endtask

    // send the queued bytes as one string, end flag on the last byte or bare
    task automatic send_str(input bit bare_end);
        int n;
        n = str_q.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(BYTE_W'($urandom), 1'b0, 1'b0);
            send_item(str_q[i], 1'b1, !bare_end && (i == n - 1));
        end
        if (bare_end || n == 0)
            send_item(BYTE_W'($urandom), 1'b0, 1'b1);
        str_q.delete();
        strings_gen++;
        if (strings_gen % 12 == 0)
            tx_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
    endtask

    // encode cp in n bytes; a short cp in a long form gives an overlong
    task automatic emit(input int unsigned cp_val, input int n);
        logic [COUNT_W-1:0] cp;
        cp = COUNT_W'(cp_val);
        case (n)
            1: put_byte({1'b0, cp[6:0]});
            2:
            begin
                put_byte(CODE_LEAD2 | {3'd0, cp[10:6]});
                put_byte(CODE_CONT | {2'd0, cp[5:0]});
            end
            3:
            begin
                put_byte(CODE_LEAD3 | {4'd0, cp[15:12]});
                put_byte(CODE_CONT | {2'd0, cp[11:6]});
                put_byte(CODE_CONT | {2'd0, cp[5:0]});
            end
            default:
            begin
                put_byte(CODE_LEAD4 | {5'd0, cp[20:18]});
                put_byte(CODE_CONT | {2'd0, cp[17:12]});
                put_byte(CODE_CONT | {2'd0, cp[11:6]});
                put_byte(CODE_CONT | {2'd0, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_char(input bit noisy);
        int r;
        r = noisy ? $urandom_range(0, 99) : $urandom_range(0, 76);
        if (r < 35)
            emit($urandom_range(1, 'h7F), 1);
        else if (r < 50)
            emit($urandom_range('h80, 'h7FF), 2);
        else if (r < 65)
            emit($urandom_range(0, 1) ? $urandom_range('h800, 'hD7FF)
                                      : $urandom_range('hE000, 'hFFFF), 3);
        else if (r < 77)
            emit($urandom_range('h10000, 'h10FFFF), 4);
        else if (r < 80)
        begin
            case ($urandom_range(2, 4))
                2: emit($urandom_range(0, 'h7F), 2);
                3: emit($urandom_range(0, 'h7FF), 3);
                default: emit($urandom_range(0, 'hFFFF), 4);
            endcase
        end
        else if (r < 83)
            emit($urandom_range('hD800, 'hDFFF), 3);
        else if (r < 86)
            emit($urandom_range('h110000, 'h1FFFFF), 4);
        else if (r < 89)
            put_byte(BYTE_W'($urandom));
        else if (r < 92)
            put_byte('0);
        else if (r < 95)
        begin
            // lead without all of its continuation bytes
            emit($urandom_range('h800, 'h10FFFF), $urandom_range(3, 4));
            str_q.delete(str_q.size() - 1);
        end
        else
            put_byte(CODE_CONT | BYTE_W'($urandom_range(0, 'h3F)));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [COUNT_W-1:0] v);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        @(posedge clk);
        limits_used++;
    endtask

    initial
    begin
        int base;
        int phase;
        int nch;
        bit noisy;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings under the reset limit
        send_str(1'b1);                             // empty string
        send_item(BYTE_W'($urandom), 1'b0, 1'b0);   // empty transaction
        emit('h7F, 1);                send_str(1'b0);
        emit('h00, 1);                send_str(1'b0);
        emit('h40, 2);                send_str(1'b0);   // C1 lead
        emit('h80, 2);
        emit('h10FFFF, 4);            send_str(1'b1);
        emit('h7FF, 3);               send_str(1'b0);   // overlong three-byte
        emit('hD800, 3);              send_str(1'b0);   // surrogate
        emit('hFFFF, 4);              send_str(1'b0);   // overlong four-byte
        emit('h110000, 4);            send_str(1'b0);   // beyond 10FFFF
        put_byte(8'hF5);              send_str(1'b0);
        put_byte(CODE_CONT);                            // stray continuation,
        put_byte(8'h41);              send_str(1'b0);   // then bytes after error
        put_byte(8'hE2);
        put_byte(8'h82);              send_str(1'b1);   // truncated at end
        limits_used = 1;

        base        = items_sent;
        strings_gen = 0;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            if (strings_gen % 30 == 0)
            begin
                phase = strings_gen / 30;
                if (phase == 0)
                    set_limit('0);
                else if (phase == 1)
                    set_limit(21'd1);
                else if (phase == 2)
                    set_limit(LIMIT_TOP);
                else
                begin
                    case ($urandom_range(0, 4))
                        0: set_limit(COUNT_W'($urandom_range(2, 24)));
                        1: set_limit(LIMIT_TOP);
                        2: set_limit(COUNT_W'($urandom_range(0, LIMIT_TOP)));
                        3: set_limit('0);
                        default: set_limit(COUNT_W'($urandom_range(0, 40)));
                    endcase
                end
            end
            if (strings_gen == 45)
            begin
                // receiver holds off while short strings pile up back to back
                hold_req = 1'b1;
                tx_max   = 0;
                repeat (10)
                begin
                    emit($urandom_range(1, 'h7F), 1);
                    send_str(1'($urandom_range(0, 1)));
                end
                drain();
                tx_max = 15;
            end
            noisy = ($urandom_range(0, 3) == 0);
            nch   = $urandom_range(0, 6);
            repeat (nch) add_char(noisy);
            send_str($urandom_range(0, 3) == 0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d strings (%0d valid, %0d invalid) from %0d transactions",
                 strings_seen, strings_valid, strings_seen - strings_valid, items_sent);
        $display("Ran under %0d length limits, mismatches: %0d", limits_used, mismatches);
        if (mismatches == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
